/* rtl/ihex_record_encoder_macros.svh */
// Assertion macros for the Intel HEX record encoder.
// Used by the top level only; depends on nothing else.
`ifndef IHEX_RECORD_ENCODER_MACROS_SVH
`define IHEX_RECORD_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IHEX_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ihex assertion failed");

// Next-cycle implication, disabled during reset.
`define IHEX_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ihex assertion failed");

`endif

/* rtl/ihex_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the Intel HEX record encoder.
// Depends on nothing; used by every module of the block.
package ihex_pkg;

    localparam logic [6:0] CHAR_COLON     = 7'h3A;
    localparam logic [6:0] CHAR_LF        = 7'h0A;
    localparam logic [7:0] MAX_RECORD_LEN = 8'd255;
    localparam logic [7:0] TYPE_DATA      = 8'h00;
    localparam logic [7:0] TYPE_EOF       = 8'h01;
    localparam logic [7:0] TYPE_EXT_LIN   = 8'h04;
    localparam logic [7:0] TYPE_START_LIN = 8'h05;
    localparam logic [7:0] LEN_EXT_LIN    = 8'h02;
    localparam logic [7:0] LEN_START_LIN  = 8'h04;

    typedef enum logic [2:0] {
        P_IDLE,
        P_EXT,
        P_HDR,
        P_DATA,
        P_CLOSE,
        P_T05,
        P_EOF
    } t_phase;

    typedef enum logic [1:0] {
        E_COLON,
        E_BYTE,
        E_SUM,
        E_LF
    } t_elem;

    typedef struct packed {
        logic        is_trailer;
        logic        need_ext;
        logic        first;
        logic        close;
        logic [31:0] addr;
        logic [7:0]  len;
        logic [7:0]  data;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_qentry;

    function automatic logic [6:0] hex_char(input logic [3:0] d);
        logic [6:0] c;
        if (d < 4'd10) begin
            c = 7'h30 + {3'b000, d};
        end else begin
            c = 7'h37 + {3'b000, d};
        end
        return c;
    endfunction

endpackage

/* rtl/ihex_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input items, tracks open records and the upper address,
// and classifies each item for the back end. Depends on ihex_pkg.
module ihex_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_cmd,
    input  logic [31:0]     i_addr_or_entry,
    input  logic [7:0]      i_rec_len,
    input  logic [7:0]      i_data_byte,
    input  logic            i_full,
    output ihex_pkg::t_qentry o_push
);
    import ihex_pkg::*;

    logic [15:0] r_upper, n_upper;
    logic [7:0]  r_left, n_left;
    logic [7:0]  len_sat;
    logic [7:0]  left_after;
    logic        first;
    logic        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        first = (r_left == 8'd0);
        if (i_rec_len == 8'd0) begin
            len_sat = 8'd1;
        end else if (i_rec_len > MAX_RECORD_LEN) begin
            len_sat = MAX_RECORD_LEN;
        end else begin
            len_sat = i_rec_len;
        end
        left_after = first ? (len_sat - 8'd1) : (r_left - 8'd1);

        o_push.valid         = accept;
        o_push.op.is_trailer = i_cmd;
        o_push.op.first      = !i_cmd && first;
        o_push.op.need_ext   = !i_cmd && first && (i_addr_or_entry[31:16] != r_upper);
        o_push.op.close      = !i_cmd && (left_after == 8'd0);
        o_push.op.addr       = i_addr_or_entry;
        o_push.op.len        = len_sat;
        o_push.op.data       = i_data_byte;

        n_upper = r_upper;
        n_left  = r_left;
        if (accept) begin
            if (i_cmd) begin
                n_left = 8'd0;
            end else begin
                n_left = left_after;
                if (first) begin
                    n_upper = i_addr_or_entry[31:16];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper <= 16'd0;
            r_left  <= 8'd0;
        end else begin
            r_upper <= n_upper;
            r_left  <= n_left;
        end
    end

endmodule

/* rtl/ihex_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue of classified items between the front and back ends.
// Depends on ihex_pkg.
module ihex_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ihex_pkg::t_qentry i_push,
    output logic              o_full,
    input  logic              i_pop,
    output ihex_pkg::t_qentry o_head
);
    import ihex_pkg::*;

    t_op        r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;

    assign o_full       = (r_count == 2'd2);
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.op    = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/ihex_back.sv */
`timescale 1ns / 1ps
// Back end: walks the head item's records and, unless stalled, emits one
// hex character per cycle into the output register. Depends on ihex_pkg.
module ihex_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ihex_pkg::t_qentry i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [6:0]        o_char_code,
    output logic              o_last_char
);
    import ihex_pkg::*;

    t_phase     r_phase, n_phase;
    logic [3:0] r_step, n_step;
    logic       r_nib, n_nib;
    logic [7:0] r_sum, n_sum;
    logic       r_valid, n_valid;
    logic [6:0] r_char, n_char;
    logic       r_last, n_last;

    t_phase     cur_phase;
    t_phase     next_phase;
    t_elem      kind;
    logic [7:0] value;
    logic [3:0] last_step;
    logic       emit;
    logic       elem_end;
    logic       done;

    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last_char = r_last;

    always_comb begin
        t_op op;
        op = i_head.op;

        if (r_phase != P_IDLE) begin
            cur_phase = r_phase;
        end else if (op.is_trailer) begin
            cur_phase = P_T05;
        end else if (op.need_ext) begin
            cur_phase = P_EXT;
        end else if (op.first) begin
            cur_phase = P_HDR;
        end else begin
            cur_phase = P_DATA;
        end

        kind       = E_BYTE;
        value      = 8'h00;
        last_step  = 4'd0;
        next_phase = P_IDLE;
        case (cur_phase)
            P_EXT: begin
                last_step  = 4'd8;
                next_phase = P_HDR;
                case (r_step)
                    4'd0:    kind  = E_COLON;
                    4'd1:    value = LEN_EXT_LIN;
                    4'd4:    value = TYPE_EXT_LIN;
                    4'd5:    value = op.addr[31:24];
                    4'd6:    value = op.addr[23:16];
                    4'd7:    kind  = E_SUM;
                    4'd8:    kind  = E_LF;
                    default: value = 8'h00;
                endcase
            end
            P_HDR: begin
                last_step  = 4'd4;
                next_phase = P_DATA;
                case (r_step)
                    4'd0:    kind  = E_COLON;
                    4'd1:    value = op.len;
                    4'd2:    value = op.addr[15:8];
                    4'd3:    value = op.addr[7:0];
                    default: value = TYPE_DATA;
                endcase
            end
            P_DATA: begin
                last_step  = 4'd0;
                next_phase = op.close ? P_CLOSE : P_IDLE;
                value      = op.data;
            end
            P_CLOSE: begin
                last_step = 4'd1;
                kind      = (r_step == 4'd0) ? E_SUM : E_LF;
            end
            P_T05: begin
                last_step  = 4'd10;
                next_phase = P_EOF;
                case (r_step)
                    4'd0:    kind  = E_COLON;
                    4'd1:    value = LEN_START_LIN;
                    4'd4:    value = TYPE_START_LIN;
                    4'd5:    value = op.addr[31:24];
                    4'd6:    value = op.addr[23:16];
                    4'd7:    value = op.addr[15:8];
                    4'd8:    value = op.addr[7:0];
                    4'd9:    kind  = E_SUM;
                    4'd10:   kind  = E_LF;
                    default: value = 8'h00;
                endcase
            end
            P_EOF: begin
                last_step = 4'd6;
                case (r_step)
                    4'd0:    kind  = E_COLON;
                    4'd4:    value = TYPE_EOF;
                    4'd5:    kind  = E_SUM;
                    4'd6:    kind  = E_LF;
                    default: value = 8'h00;
                endcase
            end
            default: begin
                kind = E_LF;
            end
        endcase
        if (kind == E_SUM) begin
            value = r_sum;
        end

        emit     = i_head.valid && (!r_valid || i_ready);
        elem_end = (kind == E_COLON) || (kind == E_LF) || r_nib;
        done     = elem_end && (r_step == last_step) && (next_phase == P_IDLE);
        o_pop    = emit && done;

        n_phase = r_phase;
        n_step  = r_step;
        n_nib   = r_nib;
        n_sum   = r_sum;
        n_valid = r_valid && !i_ready;
        n_char  = r_char;
        n_last  = r_last;

        if (emit) begin
            n_valid = 1'b1;
            n_last  = done;
            case (kind)
                E_COLON: n_char = CHAR_COLON;
                E_LF:    n_char = CHAR_LF;
                default: n_char = hex_char(r_nib ? value[3:0] : value[7:4]);
            endcase

            if (kind == E_COLON) begin
                n_sum = 8'h00;
            end else if (kind == E_BYTE && r_nib) begin
                n_sum = r_sum - value;
            end

            if (!elem_end) begin
                n_nib   = 1'b1;
                n_phase = cur_phase;
            end else begin
                n_nib = 1'b0;
                if (r_step == last_step) begin
                    n_step  = 4'd0;
                    n_phase = next_phase;
                end else begin
                    n_step  = r_step + 4'd1;
                    n_phase = cur_phase;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_step  <= 4'd0;
            r_nib   <= 1'b0;
            r_sum   <= 8'h00;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_nib   <= n_nib;
            r_sum   <= n_sum;
            r_valid <= n_valid;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
    end

endmodule

/* rtl/ihex_record_encoder.sv */
`timescale 1ns / 1ps
// Intel HEX (I32HEX) record encoder: one input item in, one ASCII character
// per output item. Characters leave one per cycle, while the output is not
// stalled, from a single output register. An item yields 2 characters for a
// data byte inside a record, 5 for the byte that closes it, 9 more when a
// byte opens a record and 16 more again when an extended linear address
// record is needed, and 32 for the trailer. A two-entry queue between the
// front end and the character sequencer lets new items be taken while
// earlier ones are still being written out. Depends on ihex_pkg,
// ihex_front, ihex_queue, ihex_back and the assertion macro header.
`include "ihex_record_encoder_macros.svh"

module ihex_record_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [31:0] i_addr_or_entry,
    input  logic [7:0]  i_rec_len,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_char_code,
    output logic        o_last_char
);
    import ihex_pkg::*;

    t_qentry push;
    t_qentry head;
    logic    full;
    logic    pop;

    ihex_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_addr_or_entry(i_addr_or_entry),
        .i_rec_len      (i_rec_len),
        .i_data_byte    (i_data_byte),
        .i_full         (full),
        .o_push         (push)
    );

    ihex_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (full),
        .i_pop  (pop),
        .o_head (head)
    );

    ihex_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char_code(o_char_code),
        .o_last_char(o_last_char)
    );

    `IHEX_ASSERT_NOW(a_pop_has_head, i_clk, i_rst_n, pop, head.valid)
    `IHEX_ASSERT_NEXT(a_push_fills_queue, i_clk, i_rst_n, i_valid && o_ready, head.valid)
    `IHEX_ASSERT_NOW(a_colon_not_last, i_clk, i_rst_n, o_valid && (o_char_code == CHAR_COLON), !o_last_char)

endmodule
